// ===== rtl/tseq_pkg.sv =====
// Shared types and constants for the sorted timer event queue.
`timescale 1ns / 1ps
package tseq_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET_RD,
        S_SET_CMP,
        S_CAN_RD,
        S_CAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TICK_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] event_code;
        logic [15:0] handle;
        logic [15:0] owner;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic        fired;
        logic [31:0] event_code;
        logic [15:0] handle;
        logic [15:0] owner;
    } result_t;
endpackage

// ===== rtl/tseq_mem.sv =====
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
module tseq_mem (
    input  logic                aclk,
    input  tseq_pkg::mem_req_t  req,
    output tseq_pkg::entry_t    rd_data
);
    tseq_pkg::entry_t mem [tseq_pkg::ENTRIES];
    tseq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/tseq_ctrl.sv =====
// Command sequencer: sorted insert, cancel search, tick pop and entry shifting.
`timescale 1ns / 1ps
module tseq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [15:0]         s_handle_in,
    input  logic [31:0]         s_event_in,
    input  logic [15:0]         s_owner_in,
    input  logic [31:0]         s_delay_ms,
    output tseq_pkg::mem_req_t  mem_req,
    input  tseq_pkg::entry_t    rd_data,
    output tseq_pkg::result_t   res,
    input  logic                res_take
);
    tseq_pkg::state_t              state_reg, state_next;
    logic [tseq_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [tseq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [31:0]                   now_reg, now_next;
    tseq_pkg::entry_t              new_reg, new_next;
    tseq_pkg::entry_t              fire_reg, fire_next;
    logic                          fired_reg, fired_next;
    tseq_pkg::status_t             status_reg, status_next;
    logic [tseq_pkg::CNT_W-1:0]    idx_dec, idx_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= tseq_pkg::S_IDLE;
            count_reg  <= '0;
            now_reg    <= '0;
            fired_reg  <= 1'b0;
            status_reg <= tseq_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            fired_reg  <= fired_next;
            status_reg <= status_next;
        end
        idx_reg  <= idx_next;
        new_reg  <= new_next;
        fire_reg <= fire_next;
    end

    assign idx_dec = idx_reg - 1'b1;
    assign idx_inc = idx_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        now_next      = now_reg;
        new_next      = new_reg;
        fire_next     = fire_reg;
        fired_next    = fired_reg;
        status_next   = status_reg;
        s_ready       = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[tseq_pkg::IDX_W-1:0];
        mem_req.wdata = new_reg;
        mem_req.raddr = idx_reg[tseq_pkg::IDX_W-1:0];
        res.valid      = (state_reg == tseq_pkg::S_DONE);
        res.status     = status_reg;
        res.fired      = fired_reg;
        res.event_code = fired_reg ? fire_reg.event_code : 32'd0;
        res.handle     = fired_reg ? fire_reg.handle : 16'd0;
        res.owner      = fired_reg ? fire_reg.owner : 16'd0;

        case (state_reg)
            tseq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    status_next = tseq_pkg::ST_OK;
                    fired_next  = 1'b0;
                    new_next.expiry     = now_reg + s_delay_ms;
                    new_next.event_code = s_event_in;
                    new_next.handle     = s_handle_in;
                    new_next.owner      = s_owner_in;
                    case (s_cmd)
                        tseq_pkg::CMD_SET: begin
                            if (count_reg >= tseq_pkg::CNT_W'(tseq_pkg::ENTRIES)) begin
                                status_next = tseq_pkg::ST_FULL;
                                state_next  = tseq_pkg::S_DONE;
                            end else begin
                                idx_next   = count_reg;
                                state_next = tseq_pkg::S_SET_RD;
                            end
                        end
                        tseq_pkg::CMD_CANCEL: begin
                            idx_next   = '0;
                            state_next = tseq_pkg::S_CAN_RD;
                        end
                        tseq_pkg::CMD_TICK: begin
                            now_next      = now_reg + 32'd1;
                            mem_req.raddr = '0;
                            if (count_reg == '0) begin
                                state_next = tseq_pkg::S_DONE;
                            end else begin
                                state_next = tseq_pkg::S_TICK_CMP;
                            end
                        end
                        default: begin
                            state_next = tseq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            tseq_pkg::S_SET_RD: begin
                if (idx_reg == '0) begin
                    mem_req.we = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = tseq_pkg::S_DONE;
                end else begin
                    mem_req.raddr = idx_dec[tseq_pkg::IDX_W-1:0];
                    state_next    = tseq_pkg::S_SET_CMP;
                end
            end
            tseq_pkg::S_SET_CMP: begin
                mem_req.we = 1'b1;
                if (rd_data.expiry > new_reg.expiry) begin
                    mem_req.wdata = rd_data;
                    idx_next      = idx_dec;
                    state_next    = tseq_pkg::S_SET_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = tseq_pkg::S_DONE;
                end
            end
            tseq_pkg::S_CAN_RD: begin
                if (idx_reg >= count_reg) begin
                    status_next = tseq_pkg::ST_NOTFOUND;
                    state_next  = tseq_pkg::S_DONE;
                end else begin
                    state_next = tseq_pkg::S_CAN_CMP;
                end
            end
            tseq_pkg::S_CAN_CMP: begin
                if (rd_data.event_code == new_reg.event_code &&
                    rd_data.owner == new_reg.owner) begin
                    state_next = tseq_pkg::S_SHIFT_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = tseq_pkg::S_CAN_RD;
                end
            end
            tseq_pkg::S_SHIFT_RD: begin
                if (idx_inc >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = tseq_pkg::S_DONE;
                end else begin
                    mem_req.raddr = idx_inc[tseq_pkg::IDX_W-1:0];
                    state_next    = tseq_pkg::S_SHIFT_WR;
                end
            end
            tseq_pkg::S_SHIFT_WR: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = rd_data;
                idx_next      = idx_inc;
                state_next    = tseq_pkg::S_SHIFT_RD;
            end
            tseq_pkg::S_TICK_CMP: begin
                if (rd_data.expiry <= now_reg) begin
                    fired_next = 1'b1;
                    fire_next  = rd_data;
                    idx_next   = '0;
                    state_next = tseq_pkg::S_SHIFT_RD;
                end else begin
                    state_next = tseq_pkg::S_DONE;
                end
            end
            tseq_pkg::S_DONE: begin
                if (res_take) begin
                    state_next = tseq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tseq_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/sorted_timer_event_queue.sv =====
// Top level of the sorted timer event queue: sequencer, entry memory, result register.
// The queue holds up to 16 timers sorted by expiry in a memory with one write port and
// one registered read port, and every request returns one result. A request is taken
// only while the sequencer is idle, but a finished result may still wait in the output
// register. Each memory step of a walk reads an entry and then compares or writes it;
// a tick shifts the table only when the head fires, a set moves up the entries with a
// later expiry, and a cancel searches for the match and then shifts the later timers
// down. After reset no clearing pass is needed.
`timescale 1ns / 1ps
module sorted_timer_event_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_handle_in,
    input  logic [31:0] s_event_in,
    input  logic [15:0] s_owner_in,
    input  logic [31:0] s_delay_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_fired,
    output logic [31:0] m_fired_event,
    output logic [15:0] m_fired_handle,
    output logic [15:0] m_fired_owner
);
    tseq_pkg::mem_req_t mem_req;
    tseq_pkg::entry_t   rd_data;
    tseq_pkg::result_t  res;
    tseq_pkg::result_t  out_reg;
    logic               res_take;

    assign res_take = !out_reg.valid || m_ready;

    tseq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_handle_in (s_handle_in),
        .s_event_in  (s_event_in),
        .s_owner_in  (s_owner_in),
        .s_delay_ms  (s_delay_ms),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .res         (res),
        .res_take    (res_take)
    );

    tseq_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (res_take) begin
            out_reg.valid <= res.valid;
        end
        if (res_take && res.valid) begin
            out_reg.status     <= res.status;
            out_reg.fired      <= res.fired;
            out_reg.event_code <= res.event_code;
            out_reg.handle     <= res.handle;
            out_reg.owner      <= res.owner;
        end
    end

    assign m_valid        = out_reg.valid;
    assign m_status       = out_reg.status;
    assign m_fired        = out_reg.fired;
    assign m_fired_event  = out_reg.event_code;
    assign m_fired_handle = out_reg.handle;
    assign m_fired_owner  = out_reg.owner;
endmodule

// ===== rtl/tseq_checker.sv =====
// Port-level assertions for the sorted timer event queue, bound to the top level.
`timescale 1ns / 1ps
module tseq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_fired,
    input logic [31:0] m_fired_event,
    input logic [15:0] m_fired_handle,
    input logic [15:0] m_fired_owner
);
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Queue took a request while still busy.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_fired))
        else $error("Result changed while stalled.");

    a_fired_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fired |-> m_fired_event == 32'd0 && m_fired_handle == 16'd0 &&
        m_fired_owner == 16'd0)
        else $error("Fired fields are not zero without a fired timer.");

    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired |-> m_status == tseq_pkg::ST_OK)
        else $error("Fired timer reported with an error status.");
endmodule

bind sorted_timer_event_queue tseq_checker u_tseq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_fired        (m_fired),
    .m_fired_event  (m_fired_event),
    .m_fired_handle (m_fired_handle),
    .m_fired_owner  (m_fired_owner)
);

// ===== tb/sorted_timer_event_queue_checker.sv =====
// Checker for the sorted timer event queue: predicts each result and compares it.
`timescale 1ns / 1ps
module sorted_timer_event_queue_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_handle_in,
    input  logic [31:0] s_event_in,
    input  logic [15:0] s_owner_in,
    input  logic [31:0] s_delay_ms,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic        m_fired,
    input  logic [31:0] m_fired_event,
    input  logic [15:0] m_fired_handle,
    input  logic [15:0] m_fired_owner,
    output int          mismatches,
    output int          outstanding,
    output int          fired_seen,
    output int          full_seen,
    output int          miss_seen
);
    typedef struct {
        tseq_pkg::status_t status;
        logic              fired;
        logic [31:0]       ev;
        logic [15:0]       hd;
        logic [15:0]       ow;
    } timer_result_t;

    timer_result_t awaited[$];

    logic [31:0] clock_ms;
    int          depth;
    logic [31:0] exp_t[tseq_pkg::ENTRIES];
    logic [31:0] ev_t[tseq_pkg::ENTRIES];
    logic [15:0] hd_t[tseq_pkg::ENTRIES];
    logic [15:0] ow_t[tseq_pkg::ENTRIES];

    function automatic void drop_timer(int pos);
        for (int i = pos; i + 1 < depth; i++) begin
            exp_t[i] = exp_t[i + 1];
            ev_t[i]  = ev_t[i + 1];
            hd_t[i]  = hd_t[i + 1];
            ow_t[i]  = ow_t[i + 1];
        end
        depth--;
    endfunction

    function automatic timer_result_t apply_request(logic [1:0] cmd, logic [15:0] hd,
                                                    logic [31:0] ev, logic [15:0] ow,
                                                    logic [31:0] dly);
        timer_result_t r;
        logic [31:0]   due;
        int            pos;
        r.status = tseq_pkg::ST_OK;
        r.fired  = 1'b0;
        r.ev     = '0;
        r.hd     = '0;
        r.ow     = '0;
        pos      = 0;
        case (cmd)
            tseq_pkg::CMD_SET: begin
                if (depth >= tseq_pkg::ENTRIES) begin
                    r.status = tseq_pkg::ST_FULL;
                end else begin
                    due = clock_ms + dly;
                    while (pos < depth && exp_t[pos] <= due) pos++;
                    for (int i = depth; i > pos; i--) begin
                        exp_t[i] = exp_t[i - 1];
                        ev_t[i]  = ev_t[i - 1];
                        hd_t[i]  = hd_t[i - 1];
                        ow_t[i]  = ow_t[i - 1];
                    end
                    exp_t[pos] = due;
                    ev_t[pos]  = ev;
                    hd_t[pos]  = hd;
                    ow_t[pos]  = ow;
                    depth++;
                end
            end
            tseq_pkg::CMD_CANCEL: begin
                while (pos < depth && !(ev_t[pos] == ev && ow_t[pos] == ow)) pos++;
                if (pos < depth) drop_timer(pos);
                else r.status = tseq_pkg::ST_NOTFOUND;
            end
            tseq_pkg::CMD_TICK: begin
                clock_ms = clock_ms + 32'd1;
                if (depth > 0 && exp_t[0] <= clock_ms) begin
                    r.fired = 1'b1;
                    r.ev    = ev_t[0];
                    r.hd    = hd_t[0];
                    r.ow    = ow_t[0];
                    drop_timer(0);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        timer_result_t want;
        if (!aresetn) begin
            clock_ms   = '0;
            depth      = 0;
            mismatches = 0;
            fired_seen = 0;
            full_seen  = 0;
            miss_seen  = 0;
            awaited.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request pending: status %0d fired %0b",
                                 $time, m_status, m_fired);
                end else begin
                    want = awaited.pop_front();
                    if (m_status !== want.status || m_fired !== want.fired ||
                        m_fired_event !== want.ev || m_fired_handle !== want.hd ||
                        m_fired_owner !== want.ow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: expected st %0d f %0b ev %h h %h o %h,",
                                      " got st %0d f %0b ev %h h %h o %h"},
                                     $time, want.status, want.fired, want.ev, want.hd,
                                     want.ow, m_status, m_fired, m_fired_event,
                                     m_fired_handle, m_fired_owner);
                    end
                    if (want.fired) fired_seen++;
                    if (want.status == tseq_pkg::ST_FULL) full_seen++;
                    if (want.status == tseq_pkg::ST_NOTFOUND) miss_seen++;
                end
            end
            if (s_valid && s_ready)
                awaited.push_back(apply_request(s_cmd, s_handle_in, s_event_in,
                                                s_owner_in, s_delay_ms));
        end
        outstanding = awaited.size();
    end
endmodule

// ===== tb/sorted_timer_event_queue_tb.sv =====
// Testbench top for the sorted timer event queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module sorted_timer_event_queue_tb;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd          = tseq_pkg::CMD_TICK;
    logic [15:0] s_handle_in    = '0;
    logic [31:0] s_event_in     = '0;
    logic [15:0] s_owner_in     = '0;
    logic [31:0] s_delay_ms     = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_status;
    logic        m_fired;
    logic [31:0] m_fired_event;
    logic [15:0] m_fired_handle;
    logic [15:0] m_fired_owner;

    int mismatches, outstanding, fired_seen, full_seen, miss_seen;
    bit calm     = 1'b0;
    bit hold_off = 1'b0;
    int sent     = 0;

    logic [31:0] live_ev[$];
    logic [15:0] live_ow[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sorted_timer_event_queue uut (.*);

    sorted_timer_event_queue_checker checker_i (.*);

    initial begin
        #30_000_000;
        $display("** sorted_timer_event_queue: FAILED **");
        $finish;
    end

    task automatic send_request(logic [1:0] cmd, logic [15:0] hd, logic [31:0] ev,
                                logic [15:0] ow, logic [31:0] dly);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_handle_in <= hd;
        s_event_in  <= ev;
        s_owner_in  <= ow;
        s_delay_ms  <= dly;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (cmd == tseq_pkg::CMD_SET) begin
            live_ev.push_back(ev);
            live_ow.push_back(ow);
            if (live_ev.size() > 32) begin
                void'(live_ev.pop_front());
                void'(live_ow.pop_front());
            end
        end
    endtask

    task automatic pause_sender(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int          counted;
        int          pick;
        int          k;
        logic [1:0]  cmd;
        logic [31:0] ev, dly;
        logic [15:0] ow;
        counted = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests: extremes, wrap of the expiry, full table and cancel misses.
        send_request(tseq_pkg::CMD_TICK, '0, '0, '0, '0);
        send_request(CMD_UNUSED, '1, '1, '1, '1);
        send_request(tseq_pkg::CMD_SET, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        send_request(tseq_pkg::CMD_SET, 16'h0000, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
        send_request(tseq_pkg::CMD_CANCEL, 16'h1234, 32'h0000_0001, 16'h0000, 32'd0);
        send_request(tseq_pkg::CMD_TICK, '1, '1, '1, '1);
        send_request(tseq_pkg::CMD_TICK, '0, '0, '0, '0);
        for (int i = 0; i < tseq_pkg::ENTRIES; i++)
            send_request(tseq_pkg::CMD_SET, 16'(i), 32'(i), 16'h0007, 32'(5 - (i % 3)));
        send_request(tseq_pkg::CMD_SET, 16'hAAAA, 32'h5555_5555, 16'h5555, 32'd1);
        send_request(tseq_pkg::CMD_CANCEL, '0, 32'd3, 16'h0007, '0);
        send_request(tseq_pkg::CMD_CANCEL, '0, 32'd3, 16'h0007, '0);

        while (counted < 1525) begin
            if (counted == 400) hold_off = 1'b1;
            if (counted == 900) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (outstanding != 0) @(posedge aclk);
            end
            if (counted == 1375) calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
            pick = $urandom_range(0, 99);
            ev   = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
            ow   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
            k    = $urandom_range(0, 99);
            if (k < 70) dly = $urandom_range(0, 30);
            else if (k < 85) dly = 32'd0;
            else if (k < 95) dly = $urandom;
            else dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
            if (pick < 45) begin
                cmd = tseq_pkg::CMD_TICK;
            end else if (pick < 80) begin
                cmd = tseq_pkg::CMD_SET;
            end else if (pick < 96) begin
                cmd = tseq_pkg::CMD_CANCEL;
                if (live_ev.size() != 0 && $urandom_range(0, 9) < 7) begin
                    k  = $urandom_range(0, live_ev.size() - 1);
                    ev = live_ev[k];
                    ow = live_ow[k];
                end
            end else begin
                cmd = CMD_UNUSED;
            end
            send_request(cmd, 16'($urandom), ev, ow, dly);
            counted++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Ran %0d requests: %0d timers fired, %0d full-table sets, %0d cancel misses.",
                 sent, fired_seen, full_seen, miss_seen);
        $display("Covered wrapped expiries, a long result stall and a full drain mid-run.");
        if (mismatches == 0)
            $display("** sorted_timer_event_queue: PASSED **");
        else
            $display("** sorted_timer_event_queue: FAILED **");
        $finish;
    end
endmodule
